### src/jsu_pkg.sv
// Shared types, character constants and decode and encode functions of the JSON string unescaper.
package jsu_pkg;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NO_QUOTE   = 3'd1,
		ERR_UNTERM_STR = 3'd2,
		ERR_CTRL       = 3'd3,
		ERR_UNTERM_ESC = 3'd4,
		ERR_BAD_ESC    = 3'd5,
		ERR_TRUNC_HEX  = 3'd6,
		ERR_BAD_HEX    = 3'd7
	} err_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		err_t       err;
	} res_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      len;
	} utf8_t;

	localparam logic [7:0]  CH_QUOTE   = 8'h22;
	localparam logic [7:0]  CH_BSLASH  = 8'h5C;
	localparam logic [7:0]  CH_U       = 8'h75;
	localparam logic [7:0]  CTRL_LIMIT = 8'h20;
	localparam logic [15:0] SURR_HI_LO = 16'hD800;
	localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LO_LO = 16'hDC00;
	localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
	localparam logic [20:0] CP_SUPP    = 21'h10000;
	localparam logic [20:0] CP_REPL    = 21'h0FFFD;
	localparam logic [7:0]  LEAD2      = 8'hC0;
	localparam logic [7:0]  LEAD3      = 8'hE0;
	localparam logic [7:0]  LEAD4      = 8'hF0;
	localparam logic [7:0]  CONT       = 8'h80;

	// Bit 4 set marks a byte that is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] d;
		case (c) inside
			[8'h30:8'h39]: d = {1'b0, c[3:0]};
			[8'h61:8'h66], [8'h41:8'h46]: d = {1'b0, 4'(c[3:0] + 4'd9)};
			default: d = 5'h10;
		endcase
		return d;
	endfunction

	// Bit 8 set marks a simple escape letter; bits 7:0 hold the byte it stands for.
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h22: r = {1'b1, 8'h22};
			8'h5C: r = {1'b1, 8'h5C};
			8'h2F: r = {1'b1, 8'h2F};
			8'h6E: r = {1'b1, 8'h0A};
			8'h72: r = {1'b1, 8'h0D};
			8'h74: r = {1'b1, 8'h09};
			8'h62: r = {1'b1, 8'h08};
			8'h66: r = {1'b1, 8'h0C};
			default: r = 9'h000;
		endcase
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t u;
		u = '0;
		if (cp < 21'h80) begin
			u.b[0] = cp[7:0];
			u.len = 3'd1;
		end else if (cp < 21'h800) begin
			u.b[0] = LEAD2 | {3'b000, cp[10:6]};
			u.b[1] = CONT | {2'b00, cp[5:0]};
			u.len = 3'd2;
		end else if (cp < 21'h10000) begin
			u.b[0] = LEAD3 | {4'b0000, cp[15:12]};
			u.b[1] = CONT | {2'b00, cp[11:6]};
			u.b[2] = CONT | {2'b00, cp[5:0]};
			u.len = 3'd3;
		end else begin
			u.b[0] = LEAD4 | {5'b00000, cp[20:18]};
			u.b[1] = CONT | {2'b00, cp[17:12]};
			u.b[2] = CONT | {2'b00, cp[11:6]};
			u.b[3] = CONT | {2'b00, cp[5:0]};
			u.len = 3'd4;
		end
		return u;
	endfunction

endpackage

### src/jsu_in_if.sv
// Input channel carrying raw string bytes and the end-of-input marker.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

### src/jsu_out_if.sv
// Output channel carrying decoded UTF-8 bytes, completion and error results.
interface jsu_out_if;
	import jsu_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	kind_t      kind;
	err_t       error_code;
	logic       last;

	modport source (output valid, output out_byte, output kind, output error_code, output last,
		input ready);
	modport sink (input valid, input out_byte, input kind, input error_code, input last,
		output ready);
endinterface

### src/json_string_unescape_utf8.sv
// JSON string unescaper: input register, single-pass decode and a four-entry result buffer.
// An accepted item is held in the input register; its results load into the result buffer once that is free.
// An item that yields zero or one result passes at one item per cycle while the output is ready; an item
// that yields n results holds the result buffer until all n are taken, one result per cycle while ready.
// Reset clears the input stage, the result buffer and the decoder state to idle.
module json_string_unescape_utf8 (
	input logic        clk,
	input logic        arst_n,
	jsu_in_if.sink     raw,
	jsu_out_if.source  decoded
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_STR,
		PH_ESC,
		PH_HEX1,
		PH_AFTER_HI,
		PH_AFTER_HI_BS,
		PH_HEX2
	} phase_t;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;

	phase_t      phase_q, ph_n;
	logic [1:0]  hc_q, hc_n;
	logic [15:0] acc_q, acc_n;
	logic [9:0]  hh_q, hh_n;
	logic        bad_q, bad_n;

	res_t        buf_q [4];
	logic [2:0]  cnt_q;

	logic [4:0]  digit;
	logic [8:0]  esc;
	logic [15:0] acc_sh;
	logic        bad_sh;
	logic        is_low;
	logic        pre;
	logic        do_sb;
	logic        do_eb;
	logic        fail_v;
	err_t        fail_code;
	logic        to_idle;
	logic        emit_one;
	res_t        one_res;
	logic        emit_cp;
	logic [20:0] cp_v;
	utf8_t       enc;
	res_t        tail [4];
	logic [2:0]  tail_n;
	res_t        load_a [4];
	logic [2:0]  load_n;

	logic        take;
	logic        buf_free;
	logic        advance;
	logic        accept;

	always_comb begin
		ph_n = phase_q;
		hc_n = hc_q;
		acc_n = acc_q;
		hh_n = hh_q;
		bad_n = bad_q;
		pre = 1'b0;
		do_sb = 1'b0;
		do_eb = 1'b0;
		fail_v = 1'b0;
		fail_code = ERR_NONE;
		to_idle = 1'b0;
		emit_one = 1'b0;
		one_res = '{data: 8'h00, kind: KIND_DATA, err: ERR_NONE};
		emit_cp = 1'b0;
		cp_v = '0;
		digit = hex_val(byte_s1);
		esc = esc_map(byte_s1);
		acc_sh = {acc_q[11:0], digit[3:0]};
		bad_sh = bad_q | digit[4];
		is_low = (acc_sh >= SURR_LO_LO) && (acc_sh <= SURR_LO_HI);

		case (phase_q)
			PH_IDLE: begin
				if (eoi_s1 || byte_s1 != CH_QUOTE) begin
					fail_v = 1'b1;
					fail_code = ERR_NO_QUOTE;
				end else begin
					ph_n = PH_STR;
				end
			end
			PH_STR: begin
				if (eoi_s1) begin
					fail_v = 1'b1;
					fail_code = ERR_UNTERM_STR;
				end else begin
					do_sb = 1'b1;
				end
			end
			PH_ESC: begin
				if (eoi_s1) begin
					fail_v = 1'b1;
					fail_code = ERR_UNTERM_ESC;
				end else begin
					do_eb = 1'b1;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (eoi_s1) begin
					fail_v = 1'b1;
					fail_code = ERR_TRUNC_HEX;
				end else begin
					bad_n = bad_sh;
					acc_n = acc_sh;
					if (hc_q != 2'd3) begin
						hc_n = hc_q + 2'd1;
					end else if (bad_sh) begin
						fail_v = 1'b1;
						fail_code = ERR_BAD_HEX;
					end else begin
						hc_n = 2'd0;
						acc_n = '0;
						if (phase_q == PH_HEX1) begin
							if (acc_sh >= SURR_HI_LO && acc_sh <= SURR_HI_HI) begin
								hh_n = acc_sh[9:0];
								ph_n = PH_AFTER_HI;
							end else begin
								emit_cp = 1'b1;
								cp_v = is_low ? CP_REPL : {5'b00000, acc_sh};
								ph_n = PH_STR;
							end
						end else begin
							emit_cp = 1'b1;
							cp_v = is_low ? CP_SUPP + {1'b0, hh_q, acc_sh[9:0]} : CP_REPL;
							hh_n = '0;
							ph_n = PH_STR;
						end
					end
				end
			end
			PH_AFTER_HI: begin
				pre = 1'b1;
				hh_n = '0;
				ph_n = PH_STR;
				if (eoi_s1) begin
					fail_v = 1'b1;
					fail_code = ERR_UNTERM_STR;
				end else if (byte_s1 == CH_BSLASH) begin
					ph_n = PH_AFTER_HI_BS;
				end else begin
					do_sb = 1'b1;
				end
			end
			PH_AFTER_HI_BS: begin
				if (!eoi_s1 && byte_s1 == CH_U) begin
					ph_n = PH_HEX2;
					hc_n = 2'd0;
					acc_n = '0;
					bad_n = 1'b0;
				end else begin
					pre = 1'b1;
					hh_n = '0;
					ph_n = PH_ESC;
					if (eoi_s1) begin
						fail_v = 1'b1;
						fail_code = ERR_UNTERM_ESC;
					end else begin
						do_eb = 1'b1;
					end
				end
			end
			default: begin
				to_idle = 1'b1;
			end
		endcase

		if (do_sb) begin
			if (byte_s1 == CH_QUOTE) begin
				emit_one = 1'b1;
				one_res.kind = KIND_DONE;
				to_idle = 1'b1;
			end else if (byte_s1 < CTRL_LIMIT) begin
				fail_v = 1'b1;
				fail_code = ERR_CTRL;
			end else if (byte_s1 == CH_BSLASH) begin
				ph_n = PH_ESC;
			end else begin
				emit_one = 1'b1;
				one_res.data = byte_s1;
			end
		end

		if (do_eb) begin
			if (esc[8]) begin
				emit_one = 1'b1;
				one_res.data = esc[7:0];
				ph_n = PH_STR;
			end else if (byte_s1 == CH_U) begin
				ph_n = PH_HEX1;
				hc_n = 2'd0;
				acc_n = '0;
				bad_n = 1'b0;
			end else begin
				fail_v = 1'b1;
				fail_code = ERR_BAD_ESC;
			end
		end

		if (fail_v) begin
			emit_one = 1'b1;
			one_res = '{data: 8'h00, kind: KIND_ERR, err: fail_code};
			to_idle = 1'b1;
		end

		if (to_idle) begin
			ph_n = PH_IDLE;
			hc_n = 2'd0;
			acc_n = '0;
			hh_n = '0;
			bad_n = 1'b0;
		end
	end

	// The replacement character, when present, always precedes at most one other result.
	always_comb begin
		enc = utf8_enc(cp_v);
		tail[0] = one_res;
		tail[1] = '{data: enc.b[1], kind: KIND_DATA, err: ERR_NONE};
		tail[2] = '{data: enc.b[2], kind: KIND_DATA, err: ERR_NONE};
		tail[3] = '{data: enc.b[3], kind: KIND_DATA, err: ERR_NONE};
		tail_n = 3'd0;
		if (emit_cp) begin
			tail[0] = '{data: enc.b[0], kind: KIND_DATA, err: ERR_NONE};
			tail_n = enc.len;
		end else if (emit_one) begin
			tail_n = 3'd1;
		end

		if (pre) begin
			load_a[0] = '{data: 8'hEF, kind: KIND_DATA, err: ERR_NONE};
			load_a[1] = '{data: 8'hBF, kind: KIND_DATA, err: ERR_NONE};
			load_a[2] = '{data: 8'hBD, kind: KIND_DATA, err: ERR_NONE};
			load_a[3] = tail[0];
			load_n = 3'd3 + tail_n;
		end else begin
			load_a = tail;
			load_n = tail_n;
		end
	end

	assign take = decoded.valid && decoded.ready;
	assign buf_free = (cnt_q == 3'd0) || (take && cnt_q == 3'd1);
	assign advance = vld_s1 && (load_n == 3'd0 || buf_free);
	assign raw.ready = !vld_s1 || advance;
	assign accept = raw.valid && raw.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			phase_q <= PH_IDLE;
			hc_q <= 2'd0;
			acc_q <= '0;
			hh_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (advance) begin
				vld_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= ph_n;
				hc_q <= hc_n;
				acc_q <= acc_n;
				hh_q <= hh_n;
				bad_q <= bad_n;
			end
			if (advance && load_n != 3'd0) begin
				cnt_q <= load_n;
			end else if (take) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= raw.in_byte;
			eoi_s1 <= raw.end_of_input;
		end
		if (advance && load_n != 3'd0) begin
			buf_q <= load_a;
		end else if (take) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
	end

	assign decoded.valid = cnt_q != 3'd0;
	assign decoded.out_byte = buf_q[0].data;
	assign decoded.kind = buf_q[0].kind;
	assign decoded.error_code = buf_q[0].err;
	assign decoded.last = cnt_q == 3'd1;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("Result buffer count exceeds its depth.");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && !decoded.last) |=> decoded.valid)
		else $error("Result burst broke off before its last result.");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && (decoded.kind == KIND_ERR || decoded.kind == KIND_DONE))
			|-> decoded.last)
		else $error("A done or error result is not the final result of its item.");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("Accepted item did not reach the input stage.");

endmodule
